### rtl/core/crm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crm_pkg
// Shared types, constants and calendar helpers for the recurrence matcher.
// ----------------------------------------------------------------------------
package crm_pkg;

   localparam int unsigned YEAR_W  = 14;
   localparam int unsigned MONTH_W = 4;
   localparam int unsigned DAY_W   = 5;
   localparam int unsigned KEY_W   = YEAR_W + MONTH_W + DAY_W;
   localparam int unsigned WSUM_W  = 15;
   localparam int unsigned CSR_W   = 14;

   localparam logic [YEAR_W-1:0]  MAX_YEAR       = 14'd9999;
   localparam logic [DAY_W-1:0]   DAYS_PER_WEEK  = 5'd7;
   localparam logic [2:0]         LAST_WEEK_CODE = 3'd5;
   localparam logic [MONTH_W-1:0] MONTH_FEB      = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_MAR      = 4'd3;
   localparam logic [MONTH_W-1:0] MONTH_DEC      = 4'd12;

   // floor(y / 100) = (y * 20972) >> 21, exact for y below 43690
   localparam logic [14:0] DIV100_MUL   = 15'd20972;
   localparam int unsigned DIV100_SHIFT = 21;
   // floor(s / 7) = (s * 9363) >> 16, exact for s below 13107
   localparam logic [13:0] DIV7_MUL     = 14'd9363;
   localparam int unsigned DIV7_SHIFT   = 16;

   // register indexes on the csr port
   localparam logic [2:0] CSR_RULE_MODE        = 3'd0;
   localparam logic [2:0] CSR_START_YEAR       = 3'd1;
   localparam logic [2:0] CSR_START_MONTH      = 3'd2;
   localparam logic [2:0] CSR_START_DAY        = 3'd3;
   localparam logic [2:0] CSR_TARGET_WEEKDAY   = 3'd4;
   localparam logic [2:0] CSR_TARGET_MONTH_DAY = 3'd5;
   localparam logic [2:0] CSR_WEEK_INDEX       = 3'd6;

   typedef enum logic [1:0] {
      RULE_DAILY       = 2'd0,
      RULE_WEEKLY      = 2'd1,
      RULE_MONTH_DAY   = 2'd2,
      RULE_NTH_WEEKDAY = 2'd3
   } rule_mode_type;

   // per-date results handed from the date pipeline to the rule stage
   typedef struct packed {
      logic              date_valid;
      logic [DAY_W-1:0]  month_len;
      logic [WSUM_W-1:0] wsum;
      logic [DAY_W-1:0]  day;
      logic [KEY_W-1:0]  key;
   } date_info_type;

   typedef struct packed {
      rule_mode_type    mode;
      logic [2:0]       target_weekday;
      logic [DAY_W-1:0] target_month_day;
      logic [2:0]       week_index;
      logic [KEY_W-1:0] start_key;
      logic             start_ok;
   } rule_cfg_type;

   function automatic logic [7:0] div_by_100(input logic [YEAR_W-1:0] y);
      logic [28:0] prod;
      prod = {15'd0, y} * {14'd0, DIV100_MUL};
      return prod[DIV100_SHIFT+7:DIV100_SHIFT];
   endfunction

   function automatic logic is_century(input logic [YEAR_W-1:0] y, input logic [7:0] q);
      logic [14:0] q100;
      q100 = {1'b0, q, 6'd0} + {2'b0, q, 5'd0} + {5'b0, q, 2'd0};
      return {1'b0, y} == q100;
   endfunction

   function automatic logic is_leap(input logic [YEAR_W-1:0] y, input logic [7:0] q);
      return (y[1:0] == 2'd0) && (!is_century(y, q) || (q[1:0] == 2'd0));
   endfunction

   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
      logic [DAY_W-1:0] len;
      case (m)
         MONTH_FEB:               len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         default:                 len = 5'd31;
      endcase
      return len;
   endfunction

   function automatic logic [2:0] month_offset(input logic [MONTH_W-1:0] m);
      logic [2:0] off;
      case (m)
         4'd2, 4'd6:  off = 3'd3;
         4'd3, 4'd11: off = 3'd2;
         4'd4:        off = 3'd5;
         4'd7:        off = 3'd5;
         4'd8:        off = 3'd1;
         4'd9, 4'd12: off = 3'd4;
         4'd10:       off = 3'd6;
         default:     off = 3'd0;
      endcase
      return off;
   endfunction

   function automatic logic date_ok(input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] m,
                                    input logic [DAY_W-1:0] d, input logic [DAY_W-1:0] len);
      return (y != '0) && (y <= MAX_YEAR) && (m != '0) && (m <= MONTH_DEC)
             && (d != '0) && (d <= len);
   endfunction

endpackage

### rtl/core/crm_date_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crm_date_pipe
// Two-stage date pipeline: century split, then validity, month length and
// the weekday sum ahead of the final mod-7.
// ----------------------------------------------------------------------------
module crm_date_pipe (
   input  logic                         clock,
   input  logic                         advance,
   input  logic [crm_pkg::YEAR_W-1:0]   year,
   input  logic [crm_pkg::MONTH_W-1:0]  month,
   input  logic [crm_pkg::DAY_W-1:0]    day,
   output crm_pkg::date_info_type       info
);
   import crm_pkg::*;

   // stage 1
   logic [YEAR_W-1:0]  y1_ff;
   logic [MONTH_W-1:0] m1_ff;
   logic [DAY_W-1:0]   d1_ff;
   logic [7:0]         q100_ff, q100_in;
   logic               cent_ff, cent_in;

   // stage 2
   date_info_type      info_ff, info_in;

   logic               leap;
   logic               jan_feb;
   logic [YEAR_W-1:0]  yy;
   logic [7:0]         qyy;
   logic [DAY_W-1:0]   len;

   always_comb begin
      q100_in = div_by_100(year);
      cent_in = is_century(year, q100_in);
   end

   always_comb begin
      leap    = is_leap(y1_ff, q100_ff);
      len     = month_days(m1_ff, leap);
      jan_feb = m1_ff < MONTH_MAR;
      // January and February count against the previous year
      yy      = jan_feb ? (y1_ff - 14'd1) : y1_ff;
      qyy     = q100_ff - {7'd0, (jan_feb && cent_ff)};
      info_in.date_valid = date_ok(y1_ff, m1_ff, d1_ff, len);
      info_in.month_len  = len;
      info_in.wsum = {1'b0, yy} + {3'd0, yy[YEAR_W-1:2]} - {7'd0, qyy}
                     + {9'd0, qyy[7:2]} + {12'd0, month_offset(m1_ff)} + {10'd0, d1_ff};
      info_in.day  = d1_ff;
      info_in.key  = {y1_ff, m1_ff, d1_ff};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         y1_ff   <= year;
         m1_ff   <= month;
         d1_ff   <= day;
         q100_ff <= q100_in;
         cent_ff <= cent_in;
         info_ff <= info_in;
      end
   end

   assign info = info_ff;

endmodule

### rtl/core/crm_rule_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crm_rule_eval
// Weekday from the registered sum, start-date gate and rule compare.
// ----------------------------------------------------------------------------
module crm_rule_eval (
   input  crm_pkg::date_info_type info,
   input  crm_pkg::rule_cfg_type  cfg,
   output logic                   occurs
);
   import crm_pkg::*;

   logic [28:0] prod;
   logic [12:0] q7;
   logic [15:0] q7x7;
   logic [15:0] rem;
   logic [2:0]  weekday;
   logic [2:0]  week_no;
   logic [DAY_W-1:0] clamp_day;
   logic        wd_hit;
   logic        rule_hit;

   always_comb begin
      prod    = {15'd0, info.wsum[13:0]} * {15'd0, DIV7_MUL};
      if (info.wsum[WSUM_W-1]) prod = '0; // out of range only for bad dates
      q7      = prod[DIV7_SHIFT+12:DIV7_SHIFT];
      q7x7    = {q7, 3'd0} - {3'd0, q7};
      rem     = {1'b0, info.wsum} - q7x7;
      weekday = (rem[2:0] == 3'd0) ? 3'd7 : rem[2:0];
      wd_hit  = weekday == cfg.target_weekday;

      // occurrence of this weekday within the month
      if (info.day <= DAYS_PER_WEEK)            week_no = 3'd1;
      else if (info.day <= 5'd14)               week_no = 3'd2;
      else if (info.day <= 5'd21)               week_no = 3'd3;
      else if (info.day <= 5'd28)               week_no = 3'd4;
      else                                      week_no = 3'd5;

      clamp_day = (cfg.target_month_day < info.month_len) ? cfg.target_month_day
                                                          : info.month_len;

      case (cfg.mode)
         RULE_DAILY:     rule_hit = 1'b1;
         RULE_WEEKLY:    rule_hit = wd_hit;
         RULE_MONTH_DAY: rule_hit = info.day == clamp_day;
         default: begin
            if (cfg.week_index == LAST_WEEK_CODE)
               rule_hit = wd_hit && (({1'b0, info.day} + {1'b0, DAYS_PER_WEEK})
                                     > {1'b0, info.month_len});
            else
               rule_hit = wd_hit && (week_no == cfg.week_index);
         end
      endcase

      occurs = info.date_valid && cfg.start_ok && (info.key >= cfg.start_key) && rule_hit;
   end

endmodule

### rtl/core/calendar_recurrence_match.sv
// Throughput: one date per cycle; the four-register pipeline only holds while
// rsp_valid is high and rsp_ready is low.
// Reset: synchronous, clears the pipeline valid bits and loads the register
// defaults (daily rule, start year 0 so nothing occurs until it is written).
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_recurrence_match
// Checks a Gregorian date against a configured recurrence rule (daily,
// weekly, monthly by day, nth weekday of month) and reports validity.
// ----------------------------------------------------------------------------
module calendar_recurrence_match (
   input  logic                        clock,
   input  logic                        reset,
   // query channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [crm_pkg::YEAR_W-1:0]  req_year,
   input  logic [crm_pkg::MONTH_W-1:0] req_month,
   input  logic [crm_pkg::DAY_W-1:0]   req_day,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_occurs,
   output logic                        rsp_date_valid,
   // register write port
   input  logic                        csr_we,
   input  logic [2:0]                  csr_index,
   input  logic [crm_pkg::CSR_W-1:0]   csr_wdata
);
   import crm_pkg::*;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   rule_mode_type      rule_mode_ff;
   logic [YEAR_W-1:0]  start_year_ff;
   logic [MONTH_W-1:0] start_month_ff;
   logic [DAY_W-1:0]   start_day_ff;
   logic [2:0]         target_weekday_ff;
   logic [DAY_W-1:0]   target_month_day_ff;
   logic [2:0]         week_index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_mode_ff        <= RULE_DAILY;
         start_year_ff       <= '0;
         start_month_ff      <= 4'd1;
         start_day_ff        <= 5'd1;
         target_weekday_ff   <= 3'd1;
         target_month_day_ff <= 5'd1;
         week_index_ff       <= 3'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RULE_MODE:        rule_mode_ff        <= rule_mode_type'(csr_wdata[1:0]);
            CSR_START_YEAR:       start_year_ff       <= csr_wdata[YEAR_W-1:0];
            CSR_START_MONTH:      start_month_ff      <= csr_wdata[MONTH_W-1:0];
            CSR_START_DAY:        start_day_ff        <= csr_wdata[DAY_W-1:0];
            CSR_TARGET_WEEKDAY:   target_weekday_ff   <= csr_wdata[2:0];
            CSR_TARGET_MONTH_DAY: target_month_day_ff <= csr_wdata[DAY_W-1:0];
            CSR_WEEK_INDEX:       week_index_ff       <= csr_wdata[2:0];
            default: ; // unmapped index, write dropped
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Start date check. Registers must change only while idle (user's rule, not
   // enforced); settling is done before a new query reaches the rule stage.
   // ---------------------------------------------------------------------
   logic [7:0]       start_q100_ff, start_q100_in;
   logic             start_ok_ff, start_ok_in;
   logic [DAY_W-1:0] start_len;

   always_comb begin
      start_q100_in = div_by_100(start_year_ff);
      start_len     = month_days(start_month_ff, is_leap(start_year_ff, start_q100_ff));
      start_ok_in   = date_ok(start_year_ff, start_month_ff, start_day_ff, start_len);
   end

   always_ff @(posedge clock) begin
      start_q100_ff <= start_q100_in;
      start_ok_ff   <= start_ok_in;
   end

   // ---------------------------------------------------------------------
   // Pipeline control: every stage moves together whenever the output
   // register is empty or being drained.
   // ---------------------------------------------------------------------
   logic advance;
   logic v0_ff, v1_ff, v2_ff, rsp_valid_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         v0_ff        <= req_valid;
         v1_ff        <= v0_ff;
         v2_ff        <= v1_ff;
         rsp_valid_ff <= v2_ff;
      end
   end

   // input register
   logic [YEAR_W-1:0]  year_ff;
   logic [MONTH_W-1:0] month_ff;
   logic [DAY_W-1:0]   day_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         year_ff  <= req_year;
         month_ff <= req_month;
         day_ff   <= req_day;
      end
   end

   // ---------------------------------------------------------------------
   // Date pipeline and rule compare
   // ---------------------------------------------------------------------
   date_info_type info;
   rule_cfg_type  cfg;
   logic          occurs_in;

   crm_date_pipe u_date_pipe (
      .clock   (clock),
      .advance (advance),
      .year    (year_ff),
      .month   (month_ff),
      .day     (day_ff),
      .info    (info)
   );

   always_comb begin
      cfg.mode             = rule_mode_ff;
      cfg.target_weekday   = target_weekday_ff;
      cfg.target_month_day = target_month_day_ff;
      cfg.week_index       = week_index_ff;
      cfg.start_key        = {start_year_ff, start_month_ff, start_day_ff};
      cfg.start_ok         = start_ok_ff;
   end

   crm_rule_eval u_rule_eval (
      .info   (info),
      .cfg    (cfg),
      .occurs (occurs_in)
   );

   // result register
   logic rsp_occurs_ff;
   logic rsp_date_valid_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_occurs_ff     <= occurs_in;
         rsp_date_valid_ff <= info.date_valid;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_occurs     = rsp_occurs_ff;
   assign rsp_date_valid = rsp_date_valid_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_occurs_needs_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_occurs_ff || rsp_date_valid_ff))
      else $error("occurs set on an invalid date");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> v0_ff)
      else $error("accepted transaction not captured");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && advance) |=> rsp_valid_ff)
      else $error("pipeline result lost before output register");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_occurs_ff)
                                        && $stable(v2_ff)))
      else $error("pipeline moved during stall");

endmodule

### tb/calendar_recurrence_match_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_recurrence_match_test
// Self-checking bench for the recurrence matcher. A scoreboard class predicts
// occurs/date_valid for each accepted date under the current rule registers
// and checks results in order. Directed edge dates come first, then a series
// of rule settings (fixed corner settings, then random ones), each followed
// by mostly well-formed random dates. Both channels idle at random, and the
// result side also takes long holds.
// ----------------------------------------------------------------------------
module calendar_recurrence_match_test;

   import crm_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 800;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned LONG_HOLD    = 150;   // receiver back-pressure stretch
   localparam int unsigned QUIET_LIMIT  = 2000;  // cycles without any transaction
   localparam logic [2:0]  CSR_UNMAPPED = 3'd7;  // no register behind this index

   // expected response for one query
   typedef struct packed {
      logic occurs;
      logic date_valid;
   } verdict_type;

   // -------------------------------------------------------------------------
   // Scoreboard: private copy of the rule registers plus a date predictor.
   // -------------------------------------------------------------------------
   class recurrence_scoreboard;
      rule_mode_type      mode;
      logic [YEAR_W-1:0]  start_year;
      logic [MONTH_W-1:0] start_month;
      logic [DAY_W-1:0]   start_day;
      logic [2:0]         want_weekday;
      logic [DAY_W-1:0]   want_month_day;
      logic [2:0]         nth_week;
      verdict_type        verdict_q[$];
      int unsigned        errors;
      int unsigned        results_seen;

      function new();
         mode           = RULE_DAILY;
         start_year     = '0;
         start_month    = 4'd1;
         start_day      = 5'd1;
         want_weekday   = 3'd1;
         want_month_day = 5'd1;
         nth_week       = 3'd1;
         errors         = 0;
         results_seen   = 0;
      endfunction

      function bit leap_year(int unsigned y);
         return (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
      endfunction

      function int unsigned days_in_month(int unsigned y, int unsigned m);
         case (m)
            2:             return leap_year(y) ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
         endcase
      endfunction

      function bit real_date(int unsigned y, int unsigned m, int unsigned d);
         if (y < 1 || y > MAX_YEAR || m < 1 || m > 12)
            return 1'b0;
         return d >= 1 && d <= days_in_month(y, m);
      endfunction

      // Monday=1 .. Sunday=7; Jan/Feb count as part of the previous year
      function int unsigned day_of_week(int unsigned y, int unsigned m, int unsigned d);
         int unsigned yy;
         int unsigned shift;
         int unsigned w;
         case (m)
            2, 6:   shift = 3;
            3, 11:  shift = 2;
            4, 7:   shift = 5;
            8:      shift = 1;
            9, 12:  shift = 4;
            10:     shift = 6;
            default: shift = 0;
         endcase
         yy = (m < 3) ? y - 1 : y;
         w  = (yy + yy / 4 - yy / 100 + yy / 400 + shift + d) % DAYS_PER_WEEK;
         return (w == 0) ? 7 : w;
      endfunction

      function verdict_type rule_verdict(logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m,
                                         logic [DAY_W-1:0] d);
         verdict_type v;
         int unsigned len;
         int unsigned wd;
         v.date_valid = real_date(y, m, d);
         v.occurs     = 1'b0;
         if (v.date_valid && real_date(start_year, start_month, start_day)
             && {y, m, d} >= {start_year, start_month, start_day}) begin
            len = days_in_month(y, m);
            wd  = day_of_week(y, m, d);
            case (mode)
               RULE_DAILY:     v.occurs = 1'b1;
               RULE_WEEKLY:    v.occurs = (wd == want_weekday);
               RULE_MONTH_DAY: v.occurs = (d == ((want_month_day < len) ? want_month_day : len));
               default: begin
                  if (wd != want_weekday)
                     v.occurs = 1'b0;
                  else if (nth_week == LAST_WEEK_CODE)
                     v.occurs = (d + DAYS_PER_WEEK > len);
                  else
                     v.occurs = ((d - 1) / DAYS_PER_WEEK + 1 == nth_week);
               end
            endcase
         end
         return v;
      endfunction

      function void apply_reg(logic [2:0] idx, logic [CSR_W-1:0] data);
         case (idx)
            CSR_RULE_MODE:        mode           = rule_mode_type'(data[1:0]);
            CSR_START_YEAR:       start_year     = data[YEAR_W-1:0];
            CSR_START_MONTH:      start_month    = data[MONTH_W-1:0];
            CSR_START_DAY:        start_day      = data[DAY_W-1:0];
            CSR_TARGET_WEEKDAY:   want_weekday   = data[2:0];
            CSR_TARGET_MONTH_DAY: want_month_day = data[DAY_W-1:0];
            CSR_WEEK_INDEX:       nth_week       = data[2:0];
            default: ;
         endcase
      endfunction

      function void note_query(logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m,
                               logic [DAY_W-1:0] d);
         verdict_q.push_back(rule_verdict(y, m, d));
      endfunction

      function void check_result(logic occurs, logic date_valid);
         verdict_type want;
         results_seen++;
         if (verdict_q.size() == 0) begin
            $error("unexpected result: occurs=%0b date_valid=%0b", occurs, date_valid);
            errors++;
            return;
         end
         want = verdict_q.pop_front();
         if (occurs !== want.occurs) begin
            $error("occurs: expected %0b, got %0b", want.occurs, occurs);
            errors++;
         end
         if (date_valid !== want.date_valid) begin
            $error("date_valid: expected %0b, got %0b", want.date_valid, date_valid);
            errors++;
         end
      endfunction

      function int unsigned pending();
         return verdict_q.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT and its signals
   // -------------------------------------------------------------------------
   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [YEAR_W-1:0]  req_year;
   logic [MONTH_W-1:0] req_month;
   logic [DAY_W-1:0]   req_day;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_occurs;
   logic               rsp_date_valid;
   logic               csr_we;
   logic [2:0]         csr_index;
   logic [CSR_W-1:0]   csr_wdata;

   recurrence_scoreboard sb;
   int unsigned          quiet_cycles;

   calendar_recurrence_match DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_year       (req_year),
      .req_month      (req_month),
      .req_day        (req_day),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_occurs     (rsp_occurs),
      .rsp_date_valid (rsp_date_valid),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // 8 ns period
   initial begin : clock_gen
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Idle length for either side: mostly none or short, now and then long.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 88)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // -------------------------------------------------------------------------
   // Monitor: both handshakes are sampled at the clock edge, before any of
   // the nonblocking updates of that edge land. Also the watchdog.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset !== 1'b1) begin
         if (req_valid === 1'b1 && req_ready === 1'b1)
            sb.note_query(req_year, req_month, req_day);
         if (rsp_valid === 1'b1 && rsp_ready === 1'b1)
            sb.check_result(rsp_occurs, rsp_date_valid);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Result sink: random ready pattern, plus two long holds while the query
   // side keeps pushing, so the pipeline fills and req_ready drops.
   // -------------------------------------------------------------------------
   initial begin : rsp_sink
      int unsigned hold_at;
      int unsigned span;
      hold_at = 200;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (sb.results_seen >= hold_at) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_at = (hold_at < 550) ? 550 : 32'hFFFF_FFFF;
         end
         span = pick_gap();
         if (span != 0) begin
            rsp_ready <= 1'b0;
            repeat (span) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         span = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 24);
         repeat (span) @(posedge clock);
      end
   end

   // -------------------------------------------------------------------------
   // Driver tasks (called at a rising edge, leave at a rising edge)
   // -------------------------------------------------------------------------

   // One query transaction; gap = idle cycles offered before it.
   task automatic send_query(input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] m,
                             input logic [DAY_W-1:0] d, input int unsigned gap);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_year  <= y;
      req_month <= m;
      req_day   <= d;
      do @(posedge clock); while (req_ready !== 1'b1);
   endtask

   // Register write; bits above the register width carry junk.
   task automatic write_reg(input logic [2:0] idx, input int unsigned value,
                            input int unsigned width);
      logic [CSR_W-1:0] data;
      data      = CSR_W'($urandom);
      data      = CSR_W'((32'(data) << width) | (value & ((32'd1 << width) - 1)));
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.apply_reg(idx, data);
   endtask

   task automatic load_rule(input rule_mode_type mode, input int unsigned sy,
                            input int unsigned sm, input int unsigned sd,
                            input int unsigned tw, input int unsigned tmd,
                            input int unsigned wi);
      write_reg(CSR_RULE_MODE, mode, 2);
      write_reg(CSR_START_YEAR, sy, YEAR_W);
      write_reg(CSR_START_MONTH, sm, MONTH_W);
      write_reg(CSR_START_DAY, sd, DAY_W);
      write_reg(CSR_TARGET_WEEKDAY, tw, 3);
      write_reg(CSR_TARGET_MONTH_DAY, tmd, DAY_W);
      write_reg(CSR_WEEK_INDEX, wi, 3);
      write_reg(CSR_UNMAPPED, $urandom, CSR_W);   // must be ignored
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Let every outstanding transaction come back, then give the pipe time.
   // The first negedge wait lets the monitor log the last accepted query.
   task automatic settle();
      req_valid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Corner settings first, random ones after.
   task automatic choose_rule(input int unsigned phase);
      rule_mode_type mode;
      int unsigned   sy, sm, sd, tw, tmd, wi, r;
      case (phase)
         0:  load_rule(RULE_WEEKLY, 1, 1, 1, 7, 31, 1);
         1:  load_rule(RULE_MONTH_DAY, 1600, 1, 1, 1, 31, 1);       // clamp to month end
         2:  load_rule(RULE_NTH_WEEKDAY, 1, 1, 1, 1, 1, LAST_WEEK_CODE);
         3:  load_rule(RULE_NTH_WEEKDAY, 1999, 12, 31, 5, 1, 3);
         4:  load_rule(RULE_DAILY, 2023, 2, 29, 1, 1, 1);           // start day not real
         5:  load_rule(RULE_DAILY, 9999, 12, 31, 7, 31, 5);         // latest possible start
         6:  load_rule(RULE_MONTH_DAY, 1, 1, 1, 1, 0, 1);           // day zero never hits
         7:  load_rule(RULE_WEEKLY, 1, 1, 1, 0, 1, 1);              // weekday zero
         8:  load_rule(RULE_NTH_WEEKDAY, 1, 1, 1, 3, 1, 7);         // bad week index
         9:  load_rule(RULE_WEEKLY, 2000, 13, 1, 2, 1, 1);          // bad start month
         10: load_rule(RULE_DAILY, 16383, 15, 31, 7, 31, 7);        // all-ones start
         default: begin
            mode = rule_mode_type'($urandom_range(0, 3));
            sy   = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 2100)
                                               : $urandom_range(1, MAX_YEAR);
            sm   = $urandom_range(1, 12);
            sd   = $urandom_range(1, sb.days_in_month(sy, sm));
            r    = $urandom_range(0, 9);
            if (r == 7)
               sy = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(MAX_YEAR + 1, 16383);
            else if (r == 8)
               sm = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(13, 15);
            else if (r == 9)
               sd = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(sb.days_in_month(sy, sm), 31);
            tw  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 7);
            r   = $urandom_range(0, 9);
            tmd = (r == 0) ? 0 : (r < 5) ? $urandom_range(28, 31) : $urandom_range(1, 31);
            r   = $urandom_range(0, 19);
            wi  = (r < 17) ? $urandom_range(1, LAST_WEEK_CODE)
                           : (r == 17) ? 0 : $urandom_range(6, 7);
            load_rule(mode, sy, sm, sd, tw, tmd, wi);
         end
      endcase
   endtask

   // Mostly real dates around the start year, some leap corners, some noise.
   function automatic void pick_date(output logic [YEAR_W-1:0] y,
                                     output logic [MONTH_W-1:0] m,
                                     output logic [DAY_W-1:0] d);
      int unsigned r, base, yr, mo, len;
      r = $urandom_range(0, 99);
      if (r < 12) begin
         y = YEAR_W'($urandom);
         m = MONTH_W'($urandom);
         d = DAY_W'($urandom);
         return;
      end
      if (r < 16) begin
         y = sb.start_year;
         m = sb.start_month;
         d = sb.start_day;
         return;
      end
      base = (sb.start_year >= 1 && sb.start_year <= MAX_YEAR) ? sb.start_year
                                                                 : $urandom_range(1, MAX_YEAR);
      r = $urandom_range(0, 9);
      if (r < 5) begin
         yr = base + $urandom_range(0, 3);
         yr = (yr > 1) ? yr - 1 : 1;
         yr = (yr > MAX_YEAR) ? MAX_YEAR : yr;
      end else if (r < 7) begin
         case ($urandom_range(0, 9))
            0: yr = 4;      1: yr = 100;   2: yr = 400;   3: yr = 1600;  4: yr = 1700;
            5: yr = 1900;   6: yr = 2000;  7: yr = 2100;  8: yr = 2400;  default: yr = 9996;
         endcase
      end else begin
         yr = $urandom_range(1, MAX_YEAR);
      end
      mo  = ($urandom_range(0, 4) == 0) ? 2 : $urandom_range(1, 12);
      len = sb.days_in_month(yr, mo);
      r   = $urandom_range(0, 99);
      y   = YEAR_W'(yr);
      m   = MONTH_W'(mo);
      if (r < 30)
         d = DAY_W'($urandom_range(len - 6, len));        // last week of the month
      else if (r < 36)
         d = (len < 31) ? DAY_W'($urandom_range(len + 1, 31)) : '0;
      else
         d = DAY_W'($urandom_range(1, len));
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin : stimulus
      logic [YEAR_W-1:0]  y;
      logic [MONTH_W-1:0] m;
      logic [DAY_W-1:0]   d;
      int unsigned        sent, phase, count;
      bit                 steady;

      sb           = new();
      quiet_cycles = 0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_year  <= '0;
      req_month <= '0;
      req_day   <= '0;
      csr_we    <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // register defaults: start year unset, nothing may occur
      send_query(14'd2024, 4'd6, 5'd15, 0);
      send_query(14'd1, 4'd1, 5'd1, 0);
      send_query(14'd9999, 4'd12, 5'd31, 1);
      settle();

      // directed dates under a daily rule starting on a leap day
      load_rule(RULE_DAILY, 2000, 2, 29, 1, 1, 1);
      send_query(14'd1, 4'd1, 5'd1, 0);
      send_query(14'd9999, 4'd12, 5'd31, 0);
      send_query(14'd0, 4'd1, 5'd1, 0);            // year zero
      send_query(14'd1, 4'd0, 5'd1, pick_gap());   // month zero
      send_query(14'd1, 4'd13, 5'd1, 0);
      send_query(14'd16383, 4'd15, 5'd31, 0);      // every input bit set
      send_query(14'd10000, 4'd1, 5'd1, 0);        // past the last year
      send_query(14'd2000, 4'd2, 5'd28, pick_gap());   // day before start
      send_query(14'd2000, 4'd2, 5'd29, 0);        // the start itself
      send_query(14'd2000, 4'd3, 5'd1, 0);
      send_query(14'd2000, 4'd2, 5'd30, 0);
      send_query(14'd1900, 4'd2, 5'd29, pick_gap());   // century, not leap
      send_query(14'd2100, 4'd2, 5'd29, 0);
      send_query(14'd2400, 4'd2, 5'd29, 0);        // 400-year leap
      send_query(14'd2023, 4'd2, 5'd29, 0);
      send_query(14'd2024, 4'd2, 5'd29, 0);
      send_query(14'd2023, 4'd4, 5'd31, pick_gap());   // 30-day month overrun
      send_query(14'd2023, 4'd4, 5'd30, 0);
      send_query(14'd2023, 4'd1, 5'd0, 0);         // day zero
      send_query(14'd2023, 4'd1, 5'd31, 0);
      send_query(14'd2023, 4'd12, 5'd31, 0);

      // random part: one rule setting per phase, drained between phases
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         settle();
         choose_rule(phase);
         steady = ($urandom_range(0, 3) == 0);
         count  = $urandom_range(25, 50);
         repeat (count) begin
            pick_date(y, m, d);
            send_query(y, m, d, steady ? 0 : pick_gap());
         end
         sent  += count;
         phase++;
      end
      settle();

      if (sb.errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
